FILE: sv/rotenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rotenc_pkg;

  // item function codes
  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_HALF_STEP   = 1'b0;
  localparam logic REG_CLICK_TICKS = 1'b1;

  localparam int unsigned ADDR_W = 3;
  localparam logic [7:0] CLICK_TICKS_RST = 8'd200;

  // direction mark, bits 5:4 of a table entry
  localparam logic [1:0] MARK_NONE  = 2'b00;
  localparam logic [1:0] MARK_RIGHT = 2'b01;

  localparam int unsigned FULL_ROWS = 7;
  localparam int unsigned HALF_ROWS = 6;

  // full-step table: next state in bits 2:0, mark in bits 5:4
  localparam logic [5:0] FULL_TAB [FULL_ROWS][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00}
  };

  // half-step table
  localparam logic [5:0] HALF_TAB [HALF_ROWS][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h04, 6'h20}
  };

  typedef struct packed {
    logic       tab_sel;
    logic [7:0] click_ticks;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic       pin_a;
    logic       pin_b;
    logic       switch_pressed;
    logic [7:0] load_value;
  } item_t;

  typedef struct packed {
    logic [7:0] position;
    logic       step_event;
    logic       step_dir;
    logic       click_event;
  } result_t;

  // table lookup; a state with no row in the selected table reads row 0
  function automatic logic [5:0] tab_lookup(input logic half, input logic [2:0] st,
                                            input logic [1:0] code);
    logic [5:0] e;
    if (half) begin
      if (32'(st) >= HALF_ROWS) e = HALF_TAB[0][code];
      else e = HALF_TAB[st][code];
    end else begin
      if (32'(st) >= FULL_ROWS) e = FULL_TAB[0][code];
      else e = FULL_TAB[st][code];
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rotenc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rotenc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rotenc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output rotenc_pkg::cfg_t                   cfg_o
);

  logic       tab_sel_q, tab_sel_d;
  logic [7:0] click_ticks_q, click_ticks_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    tab_sel_d     = tab_sel_q;
    click_ticks_d = click_ticks_q;
    if (wr_en) begin
      unique case (paddr[2])
        rotenc_pkg::REG_HALF_STEP:   tab_sel_d     = pwdata[0];
        rotenc_pkg::REG_CLICK_TICKS: click_ticks_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_sel_q     <= 1'b0;
      click_ticks_q <= rotenc_pkg::CLICK_TICKS_RST;
    end else begin
      tab_sel_q     <= tab_sel_d;
      click_ticks_q <= click_ticks_d;
    end
  end

  // read-back mux
  always_comb begin
    unique case (paddr[2])
      rotenc_pkg::REG_HALF_STEP:   prdata = {31'd0, tab_sel_q};
      rotenc_pkg::REG_CLICK_TICKS: prdata = {24'd0, click_ticks_q};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{tab_sel: tab_sel_q, click_ticks: click_ticks_q};

endmodule

`default_nettype wire

FILE: sv/rotenc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rotenc_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire rotenc_pkg::item_t   item_i,
  input  wire rotenc_pkg::cfg_t    cfg_i,
  output rotenc_pkg::result_t      res_o
);

  logic [2:0] tstate_q, tstate_d;
  logic [7:0] pos_q, pos_d;
  logic       dir_q, dir_d;
  logic [7:0] press_q, press_d;
  logic [5:0] entry;
  logic [1:0] mark;
  logic [7:0] press_inc;
  logic       step, click;

  assign entry     = rotenc_pkg::tab_lookup(cfg_i.tab_sel, tstate_q,
                                            {item_i.pin_b, item_i.pin_a});
  assign mark      = entry[5:4];
  assign press_inc = press_q + 8'd1;

  // next state of the decoder for the word in the input register
  always_comb begin
    tstate_d = tstate_q;
    pos_d    = pos_q;
    dir_d    = dir_q;
    press_d  = press_q;
    step     = 1'b0;
    click    = 1'b0;
    if (item_i.func == rotenc_pkg::FUNC_LOAD) begin
      pos_d = item_i.load_value;
    end else begin
      tstate_d = entry[2:0];
      case (mark)
        rotenc_pkg::MARK_NONE: ;
        rotenc_pkg::MARK_RIGHT: begin
          dir_d = 1'b1;
          pos_d = pos_q + 8'd1;
          step  = 1'b1;
        end
        default: begin
          dir_d = 1'b0;
          pos_d = pos_q - 8'd1;
          step  = 1'b1;
        end
      endcase
      // click counter keeps its value while released
      if (item_i.switch_pressed) begin
        if (press_inc == cfg_i.click_ticks) begin
          press_d = 8'd0;
          click   = 1'b1;
        end else begin
          press_d = press_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q <= 3'd0;
      pos_q    <= 8'd0;
      dir_q    <= 1'b0;
      press_q  <= 8'd0;
    end else if (adv_i) begin
      tstate_q <= tstate_d;
      pos_q    <= pos_d;
      dir_q    <= dir_d;
      press_q  <= press_d;
    end
  end

  assign res_o = '{position: pos_d, step_event: step, step_dir: dir_d, click_event: click};

endmodule

`default_nettype wire

FILE: sv/rotary_encoder_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// input     in         in_valid_i / in_stall_o   func, pin_a, pin_b, switch_pressed, load_value
// output    out        out_valid_o / out_stall_i position, step_event, step_dir, click_event
// config    in         APB write/read            half_step_mode, click_ticks
//
// one word per cycle sustained while the output is not stalled
// a taken word passes through the input register and the result register around the table lookup
// reset clears both valid flags, the decoder state and the config registers to their defaults
// a stalled result holds; the input register still takes a word while the result waits,
// then the input stalls until the result register frees up

module rotary_encoder_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic                          pin_a_i,
  input  wire logic                          pin_b_i,
  input  wire logic                          switch_pressed_i,
  input  wire logic [7:0]                    load_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         position_o,
  output logic                               step_event_o,
  output logic                               step_dir_o,
  output logic                               click_event_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rotenc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  rotenc_pkg::cfg_t    cfg;
  rotenc_pkg::item_t   item_q;
  rotenc_pkg::result_t res, res_q;
  logic                in_vld_q, out_vld_q;
  logic                out_free, adv, in_take;

  // pipeline control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  rotenc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func           <= func_i;
      item_q.pin_a          <= pin_a_i;
      item_q.pin_b          <= pin_b_i;
      item_q.switch_pressed <= switch_pressed_i;
      item_q.load_value     <= load_value_i;
    end
  end

  rotenc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign position_o    = res_q.position;
  assign step_event_o  = res_q.step_event;
  assign step_dir_o    = res_q.step_dir;
  assign click_event_o = res_q.click_event;

endmodule

`default_nettype wire

FILE: sv/rotenc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module rotenc_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] position_o,
  input wire logic       step_event_o,
  input wire logic       step_dir_o,
  input wire logic       click_event_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o)
      && $stable(step_event_o) && $stable(step_dir_o) && $stable(click_event_o))
    else $error("stalled result word changed");

  // the input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register free");

  // no result word in the cycle after a reset edge
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind rotary_encoder_decoder rotenc_chk u_rotenc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .position_o    (position_o),
  .step_event_o  (step_event_o),
  .step_dir_o    (step_dir_o),
  .click_event_o (click_event_o)
);

`default_nettype wire

FILE: tb/rotary_encoder_decoder_tb.sv
`timescale 1ns / 1ps

module rotary_encoder_decoder_tb;

  // quadrature tables, next state in bits 2:0 and detent mark in bits 5:4
  localparam logic [5:0] FULL_STEP_TAB [7][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00}
  };
  localparam logic [5:0] HALF_STEP_TAB [6][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h04, 6'h20}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          func_i = 1'b0;
  logic                          pin_a_i = 1'b0;
  logic                          pin_b_i = 1'b0;
  logic                          switch_pressed_i = 1'b0;
  logic [7:0]                    load_value_i = 8'd0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    position_o;
  logic                          step_event_o;
  logic                          step_dir_o;
  logic                          click_event_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rotenc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // decoder state mirrored on the bench side
  logic       half_mode = 1'b0;
  logic [7:0] click_thr = rotenc_pkg::CLICK_TICKS_RST;
  logic [2:0] dec_state = 3'd0;
  logic [7:0] pos_cnt = 8'd0;
  logic       dir_last = 1'b0;
  logic [7:0] press_cnt = 8'd0;

  rotenc_pkg::result_t due_results[$];
  int                  err_cnt = 0;
  bit                  idle_on = 1'b1;

  rotary_encoder_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .pin_a_i          (pin_a_i),
    .pin_b_i          (pin_b_i),
    .switch_pressed_i (switch_pressed_i),
    .load_value_i     (load_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_o       (position_o),
    .step_event_o     (step_event_o),
    .step_dir_o       (step_dir_o),
    .click_event_o    (click_event_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one decoder step: a position load, or a table walk, position count and click count
  function automatic rotenc_pkg::result_t decode_word(input rotenc_pkg::item_t w);
    rotenc_pkg::result_t r;
    logic [5:0]          ent;
    logic [2:0]          st;
    r = '0;
    if (w.func == rotenc_pkg::FUNC_LOAD) begin
      pos_cnt = w.load_value;
    end else begin
      st = dec_state;
      if (half_mode) begin
        if (st > 3'd5) st = 3'd0;
        ent = HALF_STEP_TAB[st][{w.pin_b, w.pin_a}];
      end else begin
        if (st > 3'd6) st = 3'd0;
        ent = FULL_STEP_TAB[st][{w.pin_b, w.pin_a}];
      end
      dec_state = ent[2:0];
      if (ent[5:4] == rotenc_pkg::MARK_RIGHT) begin
        dir_last = 1'b1;
        pos_cnt = pos_cnt + 8'd1;
        r.step_event = 1'b1;
      end else if (ent[5:4] != rotenc_pkg::MARK_NONE) begin
        dir_last = 1'b0;
        pos_cnt = pos_cnt - 8'd1;
        r.step_event = 1'b1;
      end
      if (w.switch_pressed) begin
        press_cnt = press_cnt + 8'd1;
        if (press_cnt == click_thr) begin
          press_cnt = 8'd0;
          r.click_event = 1'b1;
        end
      end
    end
    r.position = pos_cnt;
    r.step_dir = dir_last;
    return r;
  endfunction

  // gray code walk, clockwise is the right-turn order 3-1-0-2
  function automatic logic [1:0] turn_cw(input logic [1:0] c);
    case (c)
      2'd3: return 2'd1;
      2'd1: return 2'd0;
      2'd0: return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] turn_ccw(input logic [1:0] c);
    case (c)
      2'd3: return 2'd2;
      2'd2: return 2'd0;
      2'd0: return 2'd1;
      default: return 2'd3;
    endcase
  endfunction

  // send one word, with an optional gap before it
  task automatic send_word(input rotenc_pkg::item_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= w.func;
    pin_a_i          <= w.pin_a;
    pin_b_i          <= w.pin_b;
    switch_pressed_i <= w.switch_pressed;
    load_value_i     <= w.load_value;
    do @(posedge clk_i); while (in_stall_o);
    due_results.push_back(decode_word(w));
  endtask

  task automatic poll(input logic [1:0] code, input logic sw);
    rotenc_pkg::item_t w;
    w.func           = rotenc_pkg::FUNC_POLL;
    w.pin_a          = code[0];
    w.pin_b          = code[1];
    w.switch_pressed = sw;
    w.load_value     = 8'($urandom);
    send_word(w);
  endtask

  task automatic load_pos(input logic [7:0] v);
    rotenc_pkg::item_t w;
    w.func           = rotenc_pkg::FUNC_LOAD;
    w.pin_a          = 1'($urandom);
    w.pin_b          = 1'($urandom);
    w.switch_pressed = 1'($urandom);
    w.load_value     = v;
    send_word(w);
  endtask

  // drop valid and wait until every expected word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register access, setup then access cycle
  task automatic cfg_write(input logic idx, input logic [7:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rotenc_pkg::REG_HALF_STEP) half_mode = v[0];
    else click_thr = v;
  endtask

  task automatic cfg_check(input logic idx, input logic [31:0] exp_val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_val) begin
      $error("prdata: expected %0d, got %0d", exp_val, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reset values and read-back
  task automatic test_registers();
    cfg_check(rotenc_pkg::REG_HALF_STEP, 32'd0);
    cfg_check(rotenc_pkg::REG_CLICK_TICKS, 32'(rotenc_pkg::CLICK_TICKS_RST));
    cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
    cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd255);
    cfg_check(rotenc_pkg::REG_HALF_STEP, 32'd1);
    cfg_check(rotenc_pkg::REG_CLICK_TICKS, 32'd255);
  endtask

  // full-step detents, counter wrap at both ends, every pressed tick a click
  task automatic test_full_step();
    cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd0);
    cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd1);
    load_pos(8'd0);
    poll(2'd2, 1'b1); poll(2'd0, 1'b0); poll(2'd1, 1'b1); poll(2'd3, 1'b0);
    poll(2'd1, 1'b0); poll(2'd0, 1'b0); poll(2'd2, 1'b0); poll(2'd3, 1'b1);
    load_pos(8'd255);
    poll(2'd1, 1'b0); poll(2'd0, 1'b0); poll(2'd2, 1'b0); poll(2'd3, 1'b0);
    load_pos(8'hAA);
    load_pos(8'h55);
    wait_drained();
  endtask

  // half-step detents in both directions, click every third pressed tick
  task automatic test_half_step();
    cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
    cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd3);
    poll(2'd3, 1'b1); poll(2'd1, 1'b1); poll(2'd0, 1'b0);
    poll(2'd2, 1'b1); poll(2'd3, 1'b1);
    poll(2'd2, 1'b1); poll(2'd0, 1'b1); poll(2'd1, 1'b0); poll(2'd3, 1'b1);
    wait_drained();
  endtask

  // full-step state 6 has no row in the half-step table
  task automatic test_mode_switch();
    cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd0);
    poll(2'd3, 1'b0); poll(2'd2, 1'b0); poll(2'd0, 1'b0);
    wait_drained();
    cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
    poll(2'd1, 1'b0); poll(2'd0, 1'b0);
    wait_drained();
  endtask

  // zero threshold: the count only gets there by wrapping
  task automatic test_click_wrap();
    int i;
    cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd0);
    for (i = 0; i < 260; i++) poll(2'd3, 1'b1);
    wait_drained();
  endtask

  // mostly clean quadrature walks with noise, loads and switch bursts
  task automatic test_random();
    int         ph;
    int         n;
    int         r;
    logic [1:0] code;
    logic       sw;
    bit         cw;
    code = 2'd3;
    sw = 1'b0;
    cw = 1'b1;
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 5) idle_on = 1'b0;
      case (ph)
        0: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd0);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd1);
        end
        1: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd255);
        end
        2: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd0);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'($urandom_range(1, 255)));
        end
        3: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'($urandom_range(2, 20)));
        end
        4: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd0);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'd4);
        end
        default: begin
          cfg_write(rotenc_pkg::REG_HALF_STEP, 8'd1);
          cfg_write(rotenc_pkg::REG_CLICK_TICKS, 8'($urandom_range(1, 8)));
        end
      endcase
      for (n = 0; n < 170; n++) begin
        // hold the sender once until all results are back
        if (ph == 2 && n == 100) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 4) begin
          load_pos(8'($urandom));
        end else begin
          if ($urandom_range(0, 15) == 0) sw = ~sw;
          if (r < 10) begin
            code = 2'($urandom);
          end else if (r >= 20) begin
            if ($urandom_range(0, 11) == 0) cw = ~cw;
            code = cw ? turn_cw(code) : turn_ccw(code);
          end
          poll(code, sw);
        end
      end
    end
  endtask

  // receiver stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // result check against the oldest expected word
  always @(posedge clk_i) begin
    rotenc_pkg::result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        exp_r = due_results.pop_front();
        if (position_o !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, position_o);
          err_cnt++;
        end
        if (step_event_o !== exp_r.step_event) begin
          $error("step_event: expected %0d, got %0d", exp_r.step_event, step_event_o);
          err_cnt++;
        end
        if (step_dir_o !== exp_r.step_dir) begin
          $error("step_dir: expected %0d, got %0d", exp_r.step_dir, step_dir_o);
          err_cnt++;
        end
        if (click_event_o !== exp_r.click_event) begin
          $error("click_event: expected %0d, got %0d", exp_r.click_event, click_event_o);
          err_cnt++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_registers();
    test_full_step();
    test_half_step();
    test_mode_switch();
    test_click_wrap();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
